// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/nsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, constants and tables for the NTP seconds to date block.
// ----------------------------------------------------------------------------
package nsd_pkg;

    localparam logic [31:0] NTP_TO_UNIX   = 32'd2208988800;
    localparam logic [16:0] DAY_SECS      = 17'd86400;
    localparam logic [16:0] HOUR_SECS     = 17'd3600;
    localparam logic [16:0] WEEK_DAYS     = 17'd7;
    localparam logic [12:0] OFFSET_SUMMER = 13'd7200;
    localparam logic [12:0] OFFSET_WINTER = 13'd3600;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    // epoch year residues mod 4, 100, 400
    localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [8:0]  LEAP_DAYS     = 9'd366;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    localparam int QUO_BITS = 16;

    // reciprocals, rounded up: 86400 = 128*675, 3600 = 16*225
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;   // 2^35 / 675
    localparam logic [25:0] RECIP_HOUR = 26'd9321;       // 2^21 / 225
    localparam logic [25:0] RECIP_WEEK = 26'd74899;      // 2^19 / 7
    localparam int          RSH_DAY    = 35;
    localparam int          RSH_HOUR   = 21;
    localparam int          RSH_WEEK   = 19;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_RUN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        DOP_LOCAL_DAY,
        DOP_UTC_DAY,
        DOP_HOUR,
        DOP_WEEK,
        DOP_DST
    } t_div_op;

    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_HOUR,
        DSEL_WEEK
    } t_div_sel;

    typedef struct packed {
        logic    ld_input;
        logic    div_start;
        t_div_op div_op;
        logic    year_step;
        logic    month_step;
        logic    out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic year_fits;
        logic month_fits;
        logic out_free;
    } t_dp_status;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/nsd_div.sv =====
// ----------------------------------------------------------------------------
// nsd_div
// Division by 86400, 3600 or 7 through reciprocal multiplication:
// operand capture, quotient, then remainder; done rises as the remainder is registered.
// ----------------------------------------------------------------------------
module nsd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  nsd_pkg::t_div_sel            i_sel,
    input  logic [31:0]                  i_dividend,
    output logic                         o_done,
    output logic [nsd_pkg::QUO_BITS-1:0] o_quotient,
    output logic [31:0]                  o_remainder
);
    import nsd_pkg::*;

    logic                r_mul;      // quotient stage
    logic                r_back;     // remainder stage
    logic                r_done;
    t_div_sel            r_sel;
    logic [31:0]         r_num;
    logic [QUO_BITS-1:0] r_quo;
    logic [31:0]         r_rem;
    logic [24:0]         w_mul_a;
    logic [25:0]         w_mul_m;
    logic [50:0]         w_prod;
    logic [QUO_BITS-1:0] w_quo;
    logic [16:0]         w_den;
    logic [32:0]         w_back;

    // power-of-two part of the divisor shifted off before the multiply
    always_comb begin
        case (r_sel)
            DSEL_DAY: begin
                w_mul_a = r_num[31:7];
                w_mul_m = RECIP_DAY;
                w_den   = DAY_SECS;
            end
            DSEL_HOUR: begin
                w_mul_a = {12'd0, r_num[16:4]};
                w_mul_m = RECIP_HOUR;
                w_den   = HOUR_SECS;
            end
            DSEL_WEEK: begin
                w_mul_a = {9'd0, r_num[15:0]};
                w_mul_m = RECIP_WEEK;
                w_den   = WEEK_DAYS;
            end
            default: begin
                w_mul_a = r_num[31:7];
                w_mul_m = RECIP_DAY;
                w_den   = DAY_SECS;
            end
        endcase
    end

    assign w_prod = {26'd0, w_mul_a} * {25'd0, w_mul_m};

    always_comb begin
        case (r_sel)
            DSEL_DAY:  w_quo = w_prod[RSH_DAY +: QUO_BITS];
            DSEL_HOUR: w_quo = w_prod[RSH_HOUR +: QUO_BITS];
            DSEL_WEEK: w_quo = w_prod[RSH_WEEK +: QUO_BITS];
            default:   w_quo = w_prod[RSH_DAY +: QUO_BITS];
        endcase
    end

    assign w_back = {17'd0, r_quo} * {16'd0, w_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_back <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_back <= r_mul;
            r_done <= r_back;
        end
        if (i_start) begin
            r_num <= i_dividend;
            r_sel <= i_sel;
        end
        if (r_mul) begin
            r_quo <= w_quo;
        end
        if (r_back) begin
            r_rem <= r_num - w_back[31:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/nsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsd_ctrl
// Sequencer: divisions, year walk, month walk, result hand-off.
// ----------------------------------------------------------------------------
module nsd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  nsd_pkg::t_dp_status i_status,
    output nsd_pkg::t_ctrl_cmd  o_cmd
);
    import nsd_pkg::*;

    t_state  r_state, n_state;
    t_div_op r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIV_GO;
                    n_op    = DOP_LOCAL_DAY;
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (i_status.div_done) begin
                    case (r_op)
                        DOP_LOCAL_DAY: begin
                            n_state = S_DIV_GO;
                            n_op    = DOP_UTC_DAY;
                        end
                        DOP_UTC_DAY: begin
                            n_state = S_DIV_GO;
                            n_op    = DOP_HOUR;
                        end
                        DOP_HOUR: begin
                            n_state = S_DIV_GO;
                            n_op    = DOP_WEEK;
                        end
                        DOP_WEEK: n_state = S_YEAR;
                        DOP_DST:  n_state = S_DONE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_YEAR: begin
                if (i_status.year_fits) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (i_status.month_fits) begin
                    n_state = S_DIV_GO;
                    n_op    = DOP_DST;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_cmd.ld_input   = (r_state == S_IDLE) && i_valid;
        o_cmd.div_start  = (r_state == S_DIV_GO);
        o_cmd.div_op     = r_op;
        o_cmd.year_step  = (r_state == S_YEAR) && !i_status.year_fits;
        o_cmd.month_step = (r_state == S_MONTH) && !i_status.month_fits;
        o_cmd.out_load   = (r_state == S_DONE) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= DOP_LOCAL_DAY;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

// ===== rtl/nsd_dp.sv =====
// ----------------------------------------------------------------------------
// nsd_dp
// Datapath: epoch registers, divider, year/month walk, summer-time rule,
// offset store and output register.
// ----------------------------------------------------------------------------
module nsd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nsd_pkg::t_ctrl_cmd  i_cmd,
    output nsd_pkg::t_dp_status o_status,
    input  logic [31:0]         i_ntp_seconds,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [11:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day_of_month,
    output logic [2:0]          o_weekday,
    output logic [4:0]          o_hour_utc,
    output logic                o_summer_time,
    output logic [12:0]         o_new_offset
);
    import nsd_pkg::*;

    logic [31:0] r_utc;
    logic [31:0] r_local;
    logic [16:0] r_urem;       // utc mod one day
    logic [15:0] r_days;       // day count, walked down by years then months
    logic [4:0]  r_hour;
    logic [2:0]  r_wday;
    logic [11:0] r_year;
    logic [1:0]  r_mod4;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;
    logic [3:0]  r_mon;
    logic [2:0]  r_smod;
    logic [12:0] r_offset;

    logic        r_out_valid;
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [2:0]  r_o_wday;
    logic [4:0]  r_o_hour;
    logic        r_o_summer;
    logic [12:0] r_o_offset;

    logic [31:0]         w_utc;
    logic [31:0]         w_dividend;
    t_div_sel            w_div_sel;
    logic                w_div_done;
    logic [QUO_BITS-1:0] w_quo;
    logic [31:0]         w_rem;
    logic                w_leap;
    logic [8:0]          w_ylen;
    logic [4:0]          w_mlen;
    logic [14:0]         w_y5;
    logic [13:0]         w_dst_x;
    logic [2:0]          w_emod;
    logic [4:0]          w_start_day;
    logic [4:0]          w_end_day;
    logic [3:0]          w_month;
    logic [4:0]          w_day;
    logic                w_summer;

    assign w_utc = i_ntp_seconds - NTP_TO_UNIX;

    // leap year from running residues
    assign w_leap = (r_mod4 == 2'd0) && ((r_mod100 != 7'd0) || (r_mod400 == 9'd0));
    assign w_ylen = w_leap ? LEAP_DAYS : YEAR_DAYS;
    assign w_mlen = month_len(w_leap, r_mon);

    // 5*Y/4 + 4, reduced mod 7 by the divider
    assign w_y5    = {3'd0, r_year} * 15'd5;
    assign w_dst_x = {1'b0, w_y5[14:2]} + 14'd4;

    always_comb begin
        case (i_cmd.div_op)
            DOP_LOCAL_DAY: begin
                w_dividend = r_local;
                w_div_sel  = DSEL_DAY;
            end
            DOP_UTC_DAY: begin
                w_dividend = r_utc;
                w_div_sel  = DSEL_DAY;
            end
            DOP_HOUR: begin
                w_dividend = {15'd0, r_urem};
                w_div_sel  = DSEL_HOUR;
            end
            DOP_WEEK: begin
                w_dividend = {15'd0, {1'b0, r_days} + 17'd4};
                w_div_sel  = DSEL_WEEK;
            end
            DOP_DST: begin
                w_dividend = {18'd0, w_dst_x};
                w_div_sel  = DSEL_WEEK;
            end
            default: begin
                w_dividend = r_local;
                w_div_sel  = DSEL_DAY;
            end
        endcase
    end

    nsd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_sel       (w_div_sel),
        .i_dividend  (w_dividend),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // end-day residue: (x+1) mod 7 from (x+4) mod 7
    assign w_emod      = (r_smod >= 3'd3) ? (r_smod - 3'd3) : (r_smod + 3'd4);
    assign w_start_day = 5'd31 - {2'd0, r_smod};
    assign w_end_day   = 5'd31 - {2'd0, w_emod};
    assign w_month     = r_mon + 4'd1;
    assign w_day       = r_days[4:0] + 5'd1;

    always_comb begin
        w_summer = ((w_month > 4'd3) && (w_month < 4'd10))
                || ((w_month == 4'd3) && (w_day > w_start_day))
                || ((w_month == 4'd3) && (w_day == w_start_day) && (r_hour != 5'd0))
                || ((w_month == 4'd10) && (w_day < w_end_day))
                || ((w_month == 4'd10) && (w_day == w_end_day) && (r_hour == 5'd0));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_input) begin
            r_utc    <= w_utc;
            r_local  <= w_utc + {19'd0, r_offset};
            r_year   <= EPOCH_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
            r_mon    <= '0;
        end
        if (w_div_done) begin
            case (i_cmd.div_op)
                DOP_LOCAL_DAY: r_days <= w_quo;
                DOP_UTC_DAY:   r_urem <= w_rem[16:0];
                DOP_HOUR:      r_hour <= w_quo[4:0];
                DOP_WEEK:      r_wday <= w_rem[2:0];
                DOP_DST:       r_smod <= w_rem[2:0];
                default:       r_smod <= r_smod;
            endcase
        end
        if (i_cmd.year_step) begin
            r_days   <= r_days - {7'd0, w_ylen};
            r_year   <= r_year + 12'd1;
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == 7'd99)  ? 7'd0 : (r_mod100 + 7'd1);
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : (r_mod400 + 9'd1);
        end
        if (i_cmd.month_step) begin
            r_days <= r_days - {11'd0, w_mlen};
            r_mon  <= r_mon + 4'd1;
        end
        if (i_cmd.out_load) begin
            r_o_year   <= r_year;
            r_o_month  <= w_month;
            r_o_day    <= w_day;
            r_o_wday   <= r_wday;
            r_o_hour   <= r_hour;
            r_o_summer <= w_summer;
            r_o_offset <= w_summer ? OFFSET_SUMMER : OFFSET_WINTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_offset    <= w_summer ? OFFSET_SUMMER : OFFSET_WINTER;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.div_done   = w_div_done;
        o_status.year_fits  = ({7'd0, w_ylen} > r_days);
        o_status.month_fits = (r_mon == LAST_MONTH) || ({11'd0, w_mlen} > r_days);
        o_status.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_day;
    assign o_weekday      = r_o_wday;
    assign o_hour_utc     = r_o_hour;
    assign o_summer_time  = r_o_summer;
    assign o_new_offset   = r_o_offset;

endmodule

// ===== rtl/ntp_seconds_to_date_with_eu_dst_core.sv =====
// Timing: grows with Y = years past 1970 (0..136) and M = month steps (0..11);
//   worst case December 2105.
// Throughput: one item at a time; a transfer is taken only once the previous
//   result has loaded into the output register, after five reciprocal divisions
//   plus the one-year-per-cycle and one-month-per-cycle walks.
// Reset: synchronous active-low; clears the sequencer, output valid and offset.
// ----------------------------------------------------------------------------
// ntp_seconds_to_date_with_eu_dst_core
// NTP seconds to local civil date with the European summer-time rule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntp_seconds_to_date_with_eu_dst_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_ntp_seconds,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hour_utc,
    output logic        o_summer_time,
    output logic [12:0] o_new_offset
);
    import nsd_pkg::*;

    // Flow per item:
    //   transfer in  -> utc = ntp - 1900/1970 offset, local = utc + stored offset
    //   divide local by 86400 -> day count
    //   divide utc by 86400   -> seconds into UTC day
    //   divide that by 3600   -> hour_utc
    //   divide days+4 by 7    -> weekday
    //   year walk, then month walk on the day count
    //   divide 5*Y/4+4 by 7   -> last-Sunday residues for March/October
    //   rule evaluated as the result register loads; offset stored for next item
    // First item after reset sees a zero offset, so local time equals UTC.
    // The result register frees the sequencer: a finished result may wait
    // while the next transfer is taken, and only the hand-off stalls.

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    nsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    nsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_ntp_seconds  (i_ntp_seconds),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_weekday      (o_weekday),
        .o_hour_utc     (o_hour_utc),
        .o_summer_time  (o_summer_time),
        .o_new_offset   (o_new_offset)
    );

    // a taken item keeps the sequencer busy on the next cycle
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // never overwrite a result still waiting to be taken
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_valid || i_ready)
    // stored offset is one of the two legal values and matches the flag
    `ASSERT_IMPLY(a_offset_legal, i_clk, i_rst_n, o_valid,
                  o_new_offset == OFFSET_SUMMER || o_new_offset == OFFSET_WINTER)
    `ASSERT_IMPLY(a_offset_flag, i_clk, i_rst_n, o_valid,
                  o_summer_time == (o_new_offset == OFFSET_SUMMER))

endmodule
